@@ hw/rtl/pqse_pkg.sv @@
package pqse_pkg;

	localparam int CAPACITY = 256;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int PRIO_W   = 8;
	localparam int PAY_W    = 16;
	localparam int FILL_W   = 9;
	localparam int ENTRY_W  = PRIO_W + PAY_W;

	typedef enum logic [1:0] {
		KIND_ENQ     = 2'd0,
		KIND_MIN     = 2'd1,
		KIND_EXACT   = 2'd2,
		KIND_ATLEAST = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_NOMATCH = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT
	} state_t;

	typedef struct packed {
		logic              clear;
		logic              vld;
		kind_t             kind;
		logic [PRIO_W-1:0] bound;
		logic [ADDR_W-1:0] idx;
	} scan_ctrl_t;

	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] pos;
		logic [PRIO_W-1:0] prio;
		logic [PAY_W-1:0]  payload;
	} scan_res_t;

endpackage

@@ hw/rtl/pqse_ram.sv @@
module pqse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/pqse_scan.sv @@
module pqse_scan (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pqse_pkg::scan_ctrl_t        ctrl,
	input  logic [pqse_pkg::ENTRY_W-1:0] entry,
	output pqse_pkg::scan_res_t         res
);

	logic                          found_q;
	logic [pqse_pkg::ADDR_W-1:0]   pos_q;
	logic [pqse_pkg::PRIO_W-1:0]   prio_q;
	logic [pqse_pkg::PAY_W-1:0]    payload_q;
	logic [pqse_pkg::PRIO_W-1:0]   p;
	logic                          take;

	assign p = entry[pqse_pkg::ENTRY_W-1:pqse_pkg::PAY_W];

	// Strict compares keep the earliest entry on ties.
	always_comb begin
		unique case (ctrl.kind)
			pqse_pkg::KIND_MIN:     take = !found_q || (p < prio_q);
			pqse_pkg::KIND_EXACT:   take = !found_q && (p == ctrl.bound);
			pqse_pkg::KIND_ATLEAST: take = (p >= ctrl.bound) && (!found_q || (p < prio_q));
			default:                take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctrl.clear) begin
			found_q <= 1'b0;
		end else if (ctrl.vld && take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.vld && take) begin
			pos_q     <= ctrl.idx;
			prio_q    <= p;
			payload_q <= entry[pqse_pkg::PAY_W-1:0];
		end
	end

	assign res.found   = found_q;
	assign res.pos     = pos_q;
	assign res.prio    = prio_q;
	assign res.payload = payload_q;

endmodule

@@ hw/rtl/priority_queue_select_extract.sv @@
// Channel   Signals                                   Handshake
// command   kind, prio, payload                       word taken when start & !busy
// result    status, out_prio, out_payload, fill       word valid while done is high
//
// Enqueue, and any extract on an empty queue, gives its result the cycle after the
// command without raising busy. Other extracts scan all entries through the single
// memory read port, then, if an entry matched, move the later entries down one
// place and give the result; if none matched, the no-match result follows the scan.
// Reset clears the entry count and the sequencer but not the entry contents. The
// receiver cannot stall: each result is shown for exactly one cycle.
module priority_queue_select_extract (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   kind,
	input  logic [pqse_pkg::PRIO_W-1:0]  prio,
	input  logic [pqse_pkg::PAY_W-1:0]   payload,
	output logic                         done,
	output logic [1:0]                   status,
	output logic [pqse_pkg::PRIO_W-1:0]  out_prio,
	output logic [pqse_pkg::PAY_W-1:0]   out_payload,
	output logic [pqse_pkg::FILL_W-1:0]  fill
);

	pqse_pkg::state_t              state_q, state_d;
	pqse_pkg::kind_t               kind_q;
	logic [pqse_pkg::PRIO_W-1:0]   prio_q;
	logic [pqse_pkg::CNT_W-1:0]    count_q, count_d;
	logic [pqse_pkg::CNT_W-1:0]    ptr_q, ptr_val;
	logic                          rd_vld_s1;
	logic [pqse_pkg::ADDR_W-1:0]   rd_idx_s1;

	logic                          done_q;
	pqse_pkg::status_t             status_q;
	logic [pqse_pkg::PRIO_W-1:0]   out_prio_q;
	logic [pqse_pkg::PAY_W-1:0]    out_payload_q;
	logic [pqse_pkg::FILL_W-1:0]   fill_q;

	logic                          we;
	logic [pqse_pkg::ADDR_W-1:0]   waddr;
	logic [pqse_pkg::ENTRY_W-1:0]  wdata;
	logic [pqse_pkg::ENTRY_W-1:0]  rdata;

	logic                          rd_issue, ptr_load, scan_clear;
	logic                          cnt_inc, cnt_dec;
	logic                          res_load;
	pqse_pkg::status_t             res_status;
	logic [pqse_pkg::PRIO_W-1:0]   res_prio;
	logic [pqse_pkg::PAY_W-1:0]    res_payload;

	logic                          accept, ptr_end, last;
	pqse_pkg::scan_ctrl_t          sctrl;
	pqse_pkg::scan_res_t           sres;

	assign busy    = (state_q != pqse_pkg::S_IDLE);
	assign accept  = start && !busy;
	assign ptr_end = (ptr_q == count_q);
	assign last    = ptr_end && !rd_vld_s1;

	pqse_ram #(
		.WIDTH(pqse_pkg::ENTRY_W),
		.DEPTH(pqse_pkg::CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(ptr_q[pqse_pkg::ADDR_W-1:0]),
		.rdata(rdata)
	);

	assign sctrl.clear = scan_clear;
	assign sctrl.vld   = rd_vld_s1 && (state_q == pqse_pkg::S_SCAN);
	assign sctrl.kind  = kind_q;
	assign sctrl.bound = prio_q;
	assign sctrl.idx   = rd_idx_s1;

	pqse_scan u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (sctrl),
		.entry (rdata),
		.res   (sres)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pqse_pkg::S_IDLE: begin
				if (accept && (pqse_pkg::kind_t'(kind) != pqse_pkg::KIND_ENQ)
						&& (count_q != '0)) begin
					state_d = pqse_pkg::S_SCAN;
				end
			end
			pqse_pkg::S_SCAN: begin
				if (last) begin
					state_d = sres.found ? pqse_pkg::S_SHIFT : pqse_pkg::S_IDLE;
				end
			end
			pqse_pkg::S_SHIFT: begin
				if (last) begin
					state_d = pqse_pkg::S_IDLE;
				end
			end
			default: state_d = pqse_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		we          = 1'b0;
		waddr       = count_q[pqse_pkg::ADDR_W-1:0];
		wdata       = {prio, payload};
		rd_issue    = 1'b0;
		ptr_load    = 1'b0;
		ptr_val     = '0;
		scan_clear  = 1'b0;
		cnt_inc     = 1'b0;
		cnt_dec     = 1'b0;
		res_load    = 1'b0;
		res_status  = pqse_pkg::ST_OK;
		res_prio    = '0;
		res_payload = '0;
		unique case (state_q)
			pqse_pkg::S_IDLE: begin
				if (accept) begin
					if (pqse_pkg::kind_t'(kind) == pqse_pkg::KIND_ENQ) begin
						res_load = 1'b1;
						if (count_q >= pqse_pkg::CNT_W'(pqse_pkg::CAPACITY)) begin
							res_status = pqse_pkg::ST_FULL;
						end else begin
							we      = 1'b1;
							cnt_inc = 1'b1;
						end
					end else if (count_q == '0) begin
						res_load   = 1'b1;
						res_status = pqse_pkg::ST_EMPTY;
					end else begin
						scan_clear = 1'b1;
						ptr_load   = 1'b1;
					end
				end
			end
			pqse_pkg::S_SCAN: begin
				rd_issue = !ptr_end;
				if (last) begin
					if (sres.found) begin
						ptr_load = 1'b1;
						ptr_val  = pqse_pkg::CNT_W'(sres.pos) + pqse_pkg::CNT_W'(1);
					end else begin
						res_load   = 1'b1;
						res_status = pqse_pkg::ST_NOMATCH;
					end
				end
			end
			pqse_pkg::S_SHIFT: begin
				rd_issue = !ptr_end;
				we       = rd_vld_s1;
				waddr    = rd_idx_s1 - pqse_pkg::ADDR_W'(1);
				wdata    = rdata;
				if (last) begin
					cnt_dec     = 1'b1;
					res_load    = 1'b1;
					res_prio    = sres.prio;
					res_payload = sres.payload;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		count_d = count_q;
		if (cnt_inc) begin
			count_d = count_q + pqse_pkg::CNT_W'(1);
		end else if (cnt_dec) begin
			count_d = count_q - pqse_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= pqse_pkg::S_IDLE;
			count_q   <= '0;
			ptr_q     <= '0;
			rd_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			rd_vld_s1 <= rd_issue;
			done_q    <= res_load;
			if (ptr_load) begin
				ptr_q <= ptr_val;
			end else if (rd_issue) begin
				ptr_q <= ptr_q + pqse_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= ptr_q[pqse_pkg::ADDR_W-1:0];
		if (accept) begin
			kind_q <= pqse_pkg::kind_t'(kind);
			prio_q <= prio;
		end
		if (res_load) begin
			status_q      <= res_status;
			out_prio_q    <= res_prio;
			out_payload_q <= res_payload;
			fill_q        <= pqse_pkg::FILL_W'(count_d);
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign out_prio    = out_prio_q;
	assign out_payload = out_payload_q;
	assign fill        = fill_q;

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import pqse_pkg::*;

	localparam int LIMIT = 1000000;

	typedef struct {
		kind_t             kind;
		logic [PRIO_W-1:0] prio;
		logic [PAY_W-1:0]  payload;
		int unsigned       gap_pct;
		bit                hold_for_drain;
	} pq_cmd_t;

	typedef struct {
		status_t           status;
		logic [PRIO_W-1:0] prio;
		logic [PAY_W-1:0]  payload;
		logic [FILL_W-1:0] fill;
	} pq_result_t;

	typedef struct {
		logic [PRIO_W-1:0] prio;
		logic [PAY_W-1:0]  payload;
	} pq_entry_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic [1:0]          kind = '0;
	logic [PRIO_W-1:0]   prio = '0;
	logic [PAY_W-1:0]    payload = '0;
	logic                busy;
	logic                done;
	logic [1:0]          status;
	logic [PRIO_W-1:0]   out_prio;
	logic [PAY_W-1:0]    out_payload;
	logic [FILL_W-1:0]   fill;

	pq_cmd_t     cmd_queue[$];
	pq_cmd_t     cur_cmd;
	pq_result_t  pending_results[$];
	pq_result_t  want;
	pq_entry_t   pq_shadow[$];
	int unsigned issued = 0;
	int unsigned results_seen = 0;
	int unsigned errors = 0;
	int unsigned cycles = 0;

	priority_queue_select_extract dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.kind        (kind),
		.prio        (prio),
		.payload     (payload),
		.done        (done),
		.status      (status),
		.out_prio    (out_prio),
		.out_payload (out_payload),
		.fill        (fill)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb NOT OK");
			$finish;
		end
	end

	function automatic pq_result_t serve_request(pq_cmd_t c);
		pq_result_t r;
		pq_entry_t  e;
		int         pick;
		r.status = ST_OK;
		r.prio = '0;
		r.payload = '0;
		pick = -1;
		if (c.kind == KIND_ENQ) begin
			if (pq_shadow.size() >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				e.prio = c.prio;
				e.payload = c.payload;
				pq_shadow.push_back(e);
			end
		end else if (pq_shadow.size() == 0) begin
			r.status = ST_EMPTY;
		end else begin
			foreach (pq_shadow[i]) begin
				case (c.kind)
					KIND_MIN: begin
						if (pick < 0 || pq_shadow[i].prio < pq_shadow[pick].prio)
							pick = i;
					end
					KIND_EXACT: begin
						if (pick < 0 && pq_shadow[i].prio == c.prio)
							pick = i;
					end
					default: begin
						if (pq_shadow[i].prio >= c.prio &&
						    (pick < 0 || pq_shadow[i].prio < pq_shadow[pick].prio))
							pick = i;
					end
				endcase
			end
			if (pick < 0) begin
				r.status = ST_NOMATCH;
			end else begin
				r.prio = pq_shadow[pick].prio;
				r.payload = pq_shadow[pick].payload;
				pq_shadow.delete(pick);
			end
		end
		r.fill = FILL_W'(pq_shadow.size());
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [PAY_W-1:0] got,
	                               input logic [PAY_W-1:0] exp_val);
		$display("mismatch on word %0d, %s: got %0h, expected %0h",
		         results_seen, what, got, exp_val);
		errors++;
	endtask

	task automatic add_cmd(input kind_t k, input int unsigned p, input int unsigned pay,
	                       input int unsigned gap, input bit hold);
		pq_cmd_t c;
		c.kind = k;
		c.prio = PRIO_W'(p);
		c.payload = PAY_W'(pay);
		c.gap_pct = gap;
		c.hold_for_drain = hold;
		cmd_queue.push_back(c);
	endtask

	function automatic int unsigned rand_prio();
		int unsigned sel;
		sel = $urandom_range(9);
		if (sel == 0)
			return 0;
		if (sel == 1)
			return 255;
		if (sel < 6)
			return $urandom_range(0, 7);
		return $urandom_range(0, 255);
	endfunction

	always @(posedge clk or negedge arst_n) begin : drive
		pq_cmd_t     nxt;
		bit          launch;
		int unsigned in_flight;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			launch = 1'b0;
			if (start && !busy) begin
				pending_results.push_back(serve_request(cur_cmd));
				issued++;
			end
			if (!start || !busy) begin
				in_flight = issued - results_seen - int'(done);
				if (cmd_queue.size() != 0) begin
					nxt = cmd_queue[0];
					if (!(nxt.hold_for_drain && in_flight != 0) &&
					    $urandom_range(99) >= nxt.gap_pct) begin
						launch = 1'b1;
						cur_cmd = nxt;
						cmd_queue.delete(0);
					end
				end
				start <= launch;
				if (launch) begin
					kind <= nxt.kind;
					prio <= nxt.prio;
					payload <= nxt.payload;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_seen <= 0;
		end else if (done) begin
			results_seen <= results_seen + 1;
			if (pending_results.size() == 0) begin
				report_mismatch("word with none expected, status", PAY_W'(status), '0);
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status)
					report_mismatch("status", PAY_W'(status), PAY_W'(want.status));
				if (out_prio !== want.prio)
					report_mismatch("out_prio", PAY_W'(out_prio), PAY_W'(want.prio));
				if (out_payload !== want.payload)
					report_mismatch("out_payload", out_payload, want.payload);
				if (fill !== want.fill)
					report_mismatch("fill", PAY_W'(fill), PAY_W'(want.fill));
			end
		end
	end

	initial begin : stimulus
		int unsigned gaps[4];
		int unsigned n;
		int unsigned burst;
		gaps = '{0, 47, 0, 18};

		add_cmd(KIND_MIN, 0, 16'hffff, 0, 1'b0);
		add_cmd(KIND_EXACT, 255, 0, 0, 1'b0);
		add_cmd(KIND_ATLEAST, 0, 0, 0, 1'b0);
		add_cmd(KIND_ENQ, 0, 16'h0000, 0, 1'b0);
		add_cmd(KIND_ENQ, 255, 16'hffff, 0, 1'b0);
		add_cmd(KIND_ENQ, 128, 16'h8000, 0, 1'b0);
		add_cmd(KIND_ENQ, 0, 16'h1234, 0, 1'b0);
		add_cmd(KIND_EXACT, 7, 0, 0, 1'b0);
		add_cmd(KIND_ATLEAST, 255, 0, 0, 1'b0);
		add_cmd(KIND_ATLEAST, 0, 16'hffff, 0, 1'b0);
		add_cmd(KIND_EXACT, 128, 0, 0, 1'b0);
		add_cmd(KIND_ENQ, 5, 16'h00aa, 0, 1'b0);
		add_cmd(KIND_ENQ, 5, 16'h00bb, 0, 1'b0);
		add_cmd(KIND_ENQ, 3, 16'h00cc, 0, 1'b0);
		add_cmd(KIND_ATLEAST, 4, 0, 0, 1'b0);
		add_cmd(KIND_MIN, 0, 0, 0, 1'b0);
		add_cmd(KIND_EXACT, 5, 0, 0, 1'b0);
		add_cmd(KIND_ATLEAST, 4, 0, 0, 1'b0);
		add_cmd(KIND_MIN, 0, 0, 0, 1'b0);
		add_cmd(KIND_MIN, 0, 0, 0, 1'b0);

		for (int ph = 0; ph < 4; ph++) begin
			n = 0;
			while (n < 55) begin
				burst = $urandom_range(0, 10);
				for (int i = 0; i < burst; i++)
					add_cmd(KIND_ENQ, rand_prio(), $urandom_range(0, 65535), gaps[ph],
					        ph == 2 && n == 0 && i == 0);
				for (int i = 0; i < burst + $urandom_range(0, 3); i++)
					add_cmd(kind_t'($urandom_range(1, 3)), rand_prio(),
					        $urandom_range(0, 65535), gaps[ph], 1'b0);
				n += 2 * burst + 1;
			end
		end

		// The store is driven past capacity so that the last enqueues bounce.
		for (int i = 0; i < CAPACITY + 2; i++)
			add_cmd(KIND_ENQ, $urandom_range(0, 255), $urandom_range(0, 65535), 18, i == 0);
		add_cmd(KIND_EXACT, $urandom_range(0, 255), 0, 18, 1'b0);
		add_cmd(KIND_ATLEAST, 0, 0, 18, 1'b0);
		add_cmd(KIND_ATLEAST, 255, 0, 18, 1'b0);
		add_cmd(KIND_MIN, 0, 0, 18, 1'b0);
		add_cmd(KIND_ENQ, 0, 16'h5a5a, 18, 1'b0);
		add_cmd(KIND_ENQ, 0, 16'ha5a5, 18, 1'b0);
		add_cmd(KIND_ENQ, 255, 16'hffff, 18, 1'b0);
		for (int i = 0; i < 30; i++)
			add_cmd(kind_t'($urandom_range(0, 3)), rand_prio(), $urandom_range(0, 65535),
			        47, 1'b0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_queue.size() != 0 || start || issued != results_seen)
			@(negedge clk);
		repeat (2 * CAPACITY + 8) @(negedge clk);

		if (errors == 0 && pending_results.size() == 0) begin
			$display("tb OK");
		end else begin
			$display("%0d mismatches, %0d words still expected", errors,
			         pending_results.size());
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
